// ===== rtl/bvse_pkg.sv =====
package bvse_pkg;

    // field widths
    localparam int ADC_W = 15;
    localparam int CHG_W = 2;
    localparam int UV_W  = 23;
    localparam int PCT_W = 7;
    localparam int LVL_W = 2;
    localparam int STS_W = 2;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRIT_THRESHOLD = 1'd1;
    localparam logic [CFG_W-1:0] LOW_THRESHOLD_RST  = 7'd15;
    localparam logic [CFG_W-1:0] CRIT_THRESHOLD_RST = 7'd5;

    // code * 5400000 / 32768 == code * 84375 / 512
    localparam int SCALE_K_W   = 17;
    localparam logic [SCALE_K_W-1:0] SCALE_K = 17'd84375;
    localparam int SCALE_SHIFT = 9;
    localparam int ACC_W       = SCALE_K_W + 1;
    localparam int PROD_W      = ACC_W + ADC_W;
    localparam int MUL_CNT_W   = $clog2(ADC_W);

    // smoothing: (old * 3 + new) / 4
    localparam int SMOOTH_SHIFT = 2;
    localparam int SMOOTH_W     = UV_W + SMOOTH_SHIFT;

    // open-circuit-voltage curve
    localparam int OCV_POINTS = 15;
    localparam int IDX_W      = $clog2(OCV_POINTS);
    localparam int OFF_W      = 17;
    localparam int DP_W       = 4;
    localparam int NUM_W      = OFF_W + DP_W;
    localparam int Q_W        = 4;
    localparam int DIV_CNT_W  = $clog2(Q_W);
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    // charger state codes
    localparam logic [CHG_W-1:0] CHG_OFFLINE = 2'd1;
    localparam logic [CHG_W-1:0] CHG_ONLINE  = 2'd2;

    typedef enum logic [LVL_W-1:0] {
        LVL_FULL     = 2'd0,
        LVL_NORMAL   = 2'd1,
        LVL_LOW      = 2'd2,
        LVL_CRITICAL = 2'd3
    } level_t;

    typedef enum logic [STS_W-1:0] {
        STS_UNKNOWN     = 2'd0,
        STS_DISCHARGING = 2'd1,
        STS_CHARGING    = 2'd2,
        STS_FULL        = 2'd3
    } status_t;

    function automatic logic [UV_W-1:0] ocv_uv(input logic [IDX_W-1:0] idx);
        logic [UV_W-1:0] v;
        case (idx)
            4'd0:    v = 23'd4350000;
            4'd1:    v = 23'd4250000;
            4'd2:    v = 23'd4150000;
            4'd3:    v = 23'd4060000;
            4'd4:    v = 23'd3980000;
            4'd5:    v = 23'd3920000;
            4'd6:    v = 23'd3870000;
            4'd7:    v = 23'd3830000;
            4'd8:    v = 23'd3790000;
            4'd9:    v = 23'd3750000;
            4'd10:   v = 23'd3700000;
            4'd11:   v = 23'd3650000;
            4'd12:   v = 23'd3600000;
            4'd13:   v = 23'd3500000;
            4'd14:   v = 23'd3400000;
            default: v = 23'd3400000;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] ocv_pct(input logic [IDX_W-1:0] idx);
        logic [PCT_W-1:0] p;
        case (idx)
            4'd0:    p = 7'd100;
            4'd1:    p = 7'd93;
            4'd2:    p = 7'd85;
            4'd3:    p = 7'd75;
            4'd4:    p = 7'd65;
            4'd5:    p = 7'd55;
            4'd6:    p = 7'd45;
            4'd7:    p = 7'd35;
            4'd8:    p = 7'd25;
            4'd9:    p = 7'd17;
            4'd10:   p = 7'd11;
            4'd11:   p = 7'd7;
            4'd12:   p = 7'd4;
            4'd13:   p = 7'd1;
            4'd14:   p = 7'd0;
            default: p = 7'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/bvse_if.sv =====
interface bvse_in_if import bvse_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_code;
    logic             adc_ok;
    logic [CHG_W-1:0] charger_state;

    modport source (output valid, output adc_code, output adc_ok, output charger_state,
                    input ready);
    modport sink (input valid, input adc_code, input adc_ok, input charger_state,
                  output ready);
endinterface

interface bvse_out_if import bvse_pkg::*;;
    logic             valid;
    logic             ready;
    logic [UV_W-1:0]  battery_uv;
    logic [PCT_W-1:0] capacity_percent;
    logic [LVL_W-1:0] capacity_level;
    logic [STS_W-1:0] charge_status;
    logic             read_error;

    modport source (output valid, output battery_uv, output capacity_percent,
                    output capacity_level, output charge_status, output read_error,
                    input ready);
    modport sink (input valid, input battery_uv, input capacity_percent,
                  input capacity_level, input charge_status, input read_error,
                  output ready);
endinterface

// ===== rtl/bvse_interp.sv =====
module bvse_interp import bvse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [UV_W-1:0]  uv,
    output logic             done,
    output logic [PCT_W-1:0] capacity
);

    typedef enum logic [3:0] {
        I_IDLE   = 4'b0001,
        I_SEARCH = 4'b0010,
        I_MUL    = 4'b0100,
        I_DIV    = 4'b1000
    } istate_t;

    istate_t               state_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [UV_W-1:0]       uv_reg;
    logic [OFF_W-1:0]      span_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [Q_W-1:0]        q_reg;
    logic [PCT_W-1:0]      cap_reg;
    logic                  done_reg;

    logic [IDX_W-1:0]      idx_prev;
    logic [UV_W-1:0]       off_full;
    logic [UV_W-1:0]       span_full;
    logic [PCT_W-1:0]      dp_full;
    logic [NUM_W-1:0]      sub;
    logic                  ge;

    assign idx_prev  = idx_reg - IDX_W'(1);
    assign off_full  = uv_reg - ocv_uv(idx_reg);
    assign span_full = ocv_uv(idx_prev) - ocv_uv(idx_reg);
    assign dp_full   = ocv_pct(idx_prev) - ocv_pct(idx_reg);
    // restoring divide, one quotient bit a cycle, msb first
    assign sub       = NUM_W'(span_reg) << cnt_reg;
    assign ge        = rem_reg >= sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= I_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                I_IDLE:
                begin
                    if (start)
                    begin
                        uv_reg  <= uv;
                        idx_reg <= IDX_W'(1);
                        if (uv >= ocv_uv(IDX_W'(0)))
                        begin
                            cap_reg  <= PCT_FULL;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= I_SEARCH;
                        end
                    end
                end
                I_SEARCH:
                begin
                    if (uv_reg >= ocv_uv(idx_reg))
                    begin
                        state_reg <= I_MUL;
                    end
                    else if (idx_reg == IDX_W'(OCV_POINTS - 1))
                    begin
                        cap_reg   <= PCT_EMPTY;
                        done_reg  <= 1'b1;
                        state_reg <= I_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                I_MUL:
                begin
                    rem_reg   <= NUM_W'(off_full[OFF_W-1:0]) * NUM_W'(dp_full[DP_W-1:0]);
                    span_reg  <= span_full[OFF_W-1:0];
                    cnt_reg   <= DIV_CNT_W'(Q_W - 1);
                    state_reg <= I_DIV;
                end
                I_DIV:
                begin
                    q_reg <= {q_reg[Q_W-2:0], ge};
                    if (ge)
                    begin
                        rem_reg <= rem_reg - sub;
                    end
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(0))
                    begin
                        cap_reg   <= ocv_pct(idx_reg) + PCT_W'({q_reg[Q_W-2:0], ge});
                        done_reg  <= 1'b1;
                        state_reg <= I_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= I_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign capacity = cap_reg;

endmodule

// ===== rtl/battery_voltage_soc_estimator.sv =====
// channel   direction  payload
// sample    in         adc_code[14:0], adc_ok, charger_state[1:0]
// result    out        battery_uv[22:0], capacity_percent[6:0], capacity_level[1:0],
//                      charge_status[1:0], read_error
// wr_*      in         wr_index[0], wr_data[6:0], no handshake
//
// one word at a time: bit-serial scaling of the code, a smoothing step, then a table walk
// and an interpolation by multiply and restoring divide, with start, capture and load
// steps around them; a good sample passes through all of these before another is taken
// a failed sample skips the scaling; with no history it goes straight to the load step
// reset clears the history and loads the thresholds with 15 and 5
// a finished word waits in the result register; the next sample is taken meanwhile
module battery_voltage_soc_estimator import bvse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bvse_in_if.sink              sample,
    bvse_out_if.source           result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_SMOOTH = 6'b000100,
        ST_START  = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                state_reg;
    logic [CFG_W-1:0]      low_thr_reg;
    logic [CFG_W-1:0]      crit_thr_reg;
    logic [UV_W-1:0]       smoothed_reg;
    logic                  have_sample_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [ADC_W-1:0]      mq_reg;
    logic [MUL_CNT_W-1:0]  mcnt_reg;
    logic [CHG_W-1:0]      charger_reg;
    logic                  err_reg;
    logic [PCT_W-1:0]      cap_reg;

    logic                  out_valid_reg;
    logic [UV_W-1:0]       out_uv_reg;
    logic [PCT_W-1:0]      out_pct_reg;
    logic [LVL_W-1:0]      out_lvl_reg;
    logic [STS_W-1:0]      out_sts_reg;
    logic                  out_err_reg;

    logic [ACC_W-1:0]      acc_sum;
    logic [PROD_W-1:0]     prod;
    logic [UV_W-1:0]       scaled_uv;
    logic [SMOOTH_W-1:0]   smooth_sum;
    logic                  interp_done;
    logic [PCT_W-1:0]      interp_cap;
    level_t                level;
    status_t               status;
    logic                  load_out;

    bvse_interp u_interp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .uv       (smoothed_reg),
        .done     (interp_done),
        .capacity (interp_cap)
    );

    // shift-add, one code bit a cycle, lsb first
    assign acc_sum   = acc_reg + (mq_reg[0] ? ACC_W'(SCALE_K) : ACC_W'(0));
    assign prod      = {acc_reg, mq_reg};
    assign scaled_uv = prod[SCALE_SHIFT +: UV_W];
    assign smooth_sum = SMOOTH_W'({smoothed_reg, 1'b0}) + SMOOTH_W'(smoothed_reg)
                        + SMOOTH_W'(scaled_uv);

    always_comb
    begin
        if (cap_reg >= PCT_FULL)
        begin
            level = LVL_FULL;
        end
        else if (cap_reg > low_thr_reg)
        begin
            level = LVL_NORMAL;
        end
        else if (cap_reg > crit_thr_reg)
        begin
            level = LVL_LOW;
        end
        else
        begin
            level = LVL_CRITICAL;
        end

        case (charger_reg)
            CHG_OFFLINE: status = STS_DISCHARGING;
            CHG_ONLINE:  status = (cap_reg >= PCT_FULL) ? STS_FULL : STS_CHARGING;
            default:     status = STS_UNKNOWN;
        endcase
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THRESHOLD_RST;
            crit_thr_reg <= CRIT_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LOW_THRESHOLD:  low_thr_reg  <= wr_data;
                CFG_CRIT_THRESHOLD: crit_thr_reg <= wr_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            smoothed_reg    <= '0;
            have_sample_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        charger_reg <= sample.charger_state;
                        err_reg     <= 1'b0;
                        acc_reg     <= '0;
                        mq_reg      <= sample.adc_code;
                        mcnt_reg    <= '0;
                        if (sample.adc_ok)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else if (have_sample_reg)
                        begin
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_MUL:
                begin
                    {acc_reg, mq_reg} <= {acc_sum, mq_reg} >> 1;
                    mcnt_reg <= mcnt_reg + MUL_CNT_W'(1);
                    if (mcnt_reg == MUL_CNT_W'(ADC_W - 1))
                    begin
                        state_reg <= ST_SMOOTH;
                    end
                end
                ST_SMOOTH:
                begin
                    if (have_sample_reg)
                    begin
                        smoothed_reg <= smooth_sum[SMOOTH_SHIFT +: UV_W];
                    end
                    else
                    begin
                        smoothed_reg <= scaled_uv;
                    end
                    have_sample_reg <= 1'b1;
                    state_reg       <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (interp_done)
                    begin
                        cap_reg   <= interp_cap;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (err_reg)
            begin
                out_uv_reg  <= '0;
                out_pct_reg <= '0;
                out_lvl_reg <= LVL_FULL;
                out_sts_reg <= STS_UNKNOWN;
                out_err_reg <= 1'b1;
            end
            else
            begin
                out_uv_reg  <= smoothed_reg;
                out_pct_reg <= cap_reg;
                out_lvl_reg <= level;
                out_sts_reg <= status;
                out_err_reg <= 1'b0;
            end
        end
    end

    assign sample.ready            = (state_reg == ST_IDLE);
    assign result.valid            = out_valid_reg;
    assign result.battery_uv       = out_uv_reg;
    assign result.capacity_percent = out_pct_reg;
    assign result.capacity_level   = out_lvl_reg;
    assign result.charge_status    = out_sts_reg;
    assign result.read_error       = out_err_reg;

endmodule
